// ===== src/pba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Types, codes and helpers shared by the page bitmap allocator modules.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int WORD_BITS  = 64;
    localparam int CFG_W      = 9;
    localparam int ADDR_OUT_W = 26;
    localparam int CNT_W      = 15;

    localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_ALLOC_ANY = 2'd0,
        OP_ALLOC_AT  = 2'd1,
        OP_FREE      = 2'd2,
        OP_QUERY     = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] page_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_OUT_W-1:0] alloc_address;
        logic                  success;
        logic                  page_was_free;
        logic [CNT_W-1:0]      free_pages;
        logic [CNT_W-1:0]      used_pages;
        logic [CNT_W-1:0]      total_pages;
    } rsp_t;

    typedef struct packed {
        logic clr_we;
        logic load;
        logic rd_tgt;
        logic decide;
        logic take_tgt;
        logic free_tgt;
        logic scan_from_lf;
        logic scan_from_next;
        logic scan_rd;
        logic scan_step;
        logic take_hit;
        logic lf_hit;
        logic lf_none;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic tgt_in_range;
        logic tgt_bit_set;
        logic tgt_eq_lf;
        logic scan_oob;
        logic scan_next_oob;
        logic scan_hit;
        logic clr_last;
    } status_t;

    // index of the lowest set bit
    function automatic logic [5:0] first_one(input logic [WORD_BITS-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== src/pba_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for the allocator: clear pass, page lookup and next-free scans.
// ----------------------------------------------------------------------------
module pba_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pba_pkg::op_t    req_op,
    input  wire pba_pkg::status_t status,
    output pba_pkg::cmd_t        cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (req_op == pba_pkg::OP_ALLOC_ANY)
                    begin
                        cmd.scan_from_lf = 1'b1;
                        first_next       = 1'b1;
                        state_next       = S_SCAN_RD;
                    end
                    else
                    begin
                        first_next = 1'b0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_tgt = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_RESULT;
                if (status.op == pba_pkg::OP_ALLOC_AT && status.tgt_in_range &&
                    !status.tgt_bit_set)
                begin
                    cmd.take_tgt = 1'b1;
                    if (status.tgt_eq_lf)
                    begin
                        cmd.scan_from_next = 1'b1;
                        state_next         = S_SCAN_RD;
                    end
                end
                else if (status.op == pba_pkg::OP_FREE && status.tgt_in_range &&
                         status.tgt_bit_set)
                begin
                    cmd.free_tgt = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                if (status.scan_oob)
                begin
                    cmd.lf_none = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (status.scan_hit)
                begin
                    if (first_reg)
                    begin
                        cmd.take_hit = 1'b1;
                        first_next   = 1'b0;
                        state_next   = S_SCAN_RD;
                    end
                    else
                    begin
                        cmd.lf_hit = 1'b1;
                        state_next = S_RESULT;
                    end
                end
                else if (status.scan_next_oob)
                begin
                    cmd.lf_none = 1'b1;
                    state_next  = S_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
        done_next = (state_next == S_RESULT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            first_reg <= 1'b0;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while not busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

endmodule
`default_nettype wire

// ===== src/pba_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pba_datapath
// Page bitmap memory, free count, lowest-free pointer, scan pointer and result.
// ----------------------------------------------------------------------------
module pba_datapath #(
    parameter int MAP_WORDS  = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pba_pkg::cmd_t                cmd,
    input  wire pba_pkg::req_t                req,
    input  wire logic                         cfg_we,
    input  wire logic [pba_pkg::CFG_W-1:0]    cfg_data,
    output pba_pkg::status_t                  status,
    output pba_pkg::rsp_t                     rsp
);

    localparam int LOG_PB    = $clog2(PAGE_BYTES);
    localparam int PW        = 32 - LOG_PB;
    localparam int NO_PAGE_V = MAP_WORDS * 64;
    localparam int PG_W      = $clog2(NO_PAGE_V + 1);
    localparam int TW        = (PW > PG_W) ? PW : PG_W;
    localparam int SPW       = TW + 1;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int EW        = $clog2(MAP_WORDS + 1);
    localparam int LW        = (EW > pba_pkg::CFG_W) ? EW : pba_pkg::CFG_W;
    localparam int UW        = (PG_W > LW + 6) ? PG_W : LW + 6;
    localparam int WB        = pba_pkg::WORD_BITS;

    localparam logic [PG_W-1:0] NO_PAGE = PG_W'(NO_PAGE_V);

    logic [WB-1:0] mem [MAP_WORDS];
    logic [WB-1:0] rdata_reg;

    logic [pba_pkg::CFG_W-1:0] wiu_reg;
    logic [PG_W-1:0]           fc_reg;
    logic [PG_W-1:0]           lf_reg;
    logic [AW-1:0]             clr_cnt_reg;
    logic [TW-1:0]             tgt_reg;
    logic [SPW-1:0]            scan_page_reg;
    pba_pkg::op_t              op_reg;
    logic                      ok_reg;
    logic                      was_free_reg;

    logic [LW-1:0]      eff;
    logic [TW-7:0]      tgt_word;
    logic [SPW-7:0]     scan_word;
    logic [SPW-7:0]     scan_word_inc;
    logic [WB-1:0]      cand;
    logic [5:0]         hit_idx;
    logic [SPW-1:0]     hit_page;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [WB-1:0]      wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [UW-1:0]      total_u;
    logic [UW-1:0]      fc_u;
    logic [UW-1:0]      used_u;
    logic [TW+LOG_PB-1:0] addr_full;

    assign eff = (LW'(wiu_reg) > LW'(MAP_WORDS)) ? LW'(MAP_WORDS) : LW'(wiu_reg);

    assign tgt_word      = tgt_reg[TW-1:6];
    assign scan_word     = scan_page_reg[SPW-1:6];
    assign scan_word_inc = scan_word + (SPW-6)'(1);
    assign cand          = ~rdata_reg & ({WB{1'b1}} << scan_page_reg[5:0]);
    assign hit_idx       = pba_pkg::first_one(cand);
    assign hit_page      = {scan_word, hit_idx};

    always_comb
    begin
        status               = '0;
        status.op            = op_reg;
        status.tgt_in_range  = TW'(tgt_word) < TW'(eff);
        status.tgt_bit_set   = rdata_reg[tgt_reg[5:0]];
        status.tgt_eq_lf     = (tgt_reg == TW'(lf_reg));
        status.scan_oob      = SPW'(scan_word) >= SPW'(eff);
        status.scan_next_oob = (SPW'(scan_word) + SPW'(1)) >= SPW'(eff);
        status.scan_hit      = |cand;
        status.clr_last      = (clr_cnt_reg == AW'(MAP_WORDS - 1));
    end

    // memory port muxing
    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_word[AW-1:0];
        wdata = rdata_reg;
        if (cmd.clr_we)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = {WB{1'b1}};
        end
        else if (cmd.take_tgt)
        begin
            we    = 1'b1;
            wdata = rdata_reg | (WB'(1) << tgt_reg[5:0]);
        end
        else if (cmd.free_tgt)
        begin
            we    = 1'b1;
            wdata = rdata_reg & ~(WB'(1) << tgt_reg[5:0]);
        end
        else if (cmd.take_hit)
        begin
            we    = 1'b1;
            waddr = scan_word[AW-1:0];
            wdata = rdata_reg | (WB'(1) << hit_idx);
        end

        re    = cmd.rd_tgt | cmd.scan_rd | cmd.scan_step;
        raddr = tgt_word[AW-1:0];
        if (cmd.scan_rd)
        begin
            raddr = scan_word[AW-1:0];
        end
        else if (cmd.scan_step)
        begin
            raddr = scan_word_inc[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wiu_reg     <= pba_pkg::WORDS_IN_USE_RESET;
            fc_reg      <= '0;
            lf_reg      <= NO_PAGE;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wiu_reg <= cfg_data;
            end
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.take_tgt || cmd.take_hit)
            begin
                if (fc_reg != '0)
                begin
                    fc_reg <= fc_reg - PG_W'(1);
                end
            end
            else if (cmd.free_tgt)
            begin
                fc_reg <= fc_reg + PG_W'(1);
            end
            if (cmd.take_hit || cmd.lf_hit)
            begin
                lf_reg <= hit_page[PG_W-1:0];
            end
            else if (cmd.free_tgt && (tgt_reg < TW'(lf_reg)))
            begin
                lf_reg <= tgt_reg[PG_W-1:0];
            end
            else if (cmd.lf_none)
            begin
                lf_reg <= NO_PAGE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req.op;
            tgt_reg      <= TW'(req.page_address[31:LOG_PB]);
            ok_reg       <= 1'b0;
            was_free_reg <= 1'b0;
        end
        if (cmd.decide)
        begin
            was_free_reg <= status.tgt_in_range & ~status.tgt_bit_set;
        end
        if (cmd.take_tgt || cmd.free_tgt)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.take_hit)
        begin
            tgt_reg      <= hit_page[TW-1:0];
            ok_reg       <= 1'b1;
            was_free_reg <= 1'b1;
        end
        if (cmd.scan_from_lf)
        begin
            scan_page_reg <= SPW'(lf_reg);
        end
        else if (cmd.scan_from_next)
        begin
            scan_page_reg <= SPW'(tgt_reg) + SPW'(1);
        end
        else if (cmd.take_hit)
        begin
            scan_page_reg <= hit_page + SPW'(1);
        end
        else if (cmd.scan_step)
        begin
            scan_page_reg <= {scan_word_inc, 6'b0};
        end
    end

    assign total_u   = UW'({eff, 6'b0});
    assign fc_u      = UW'(fc_reg);
    assign used_u    = (total_u > fc_u) ? (total_u - fc_u) : '0;
    assign addr_full = {tgt_reg, {LOG_PB{1'b0}}};

    always_comb
    begin
        rsp               = '0;
        rsp.alloc_address = (ok_reg && op_reg == pba_pkg::OP_ALLOC_ANY) ?
                            addr_full[pba_pkg::ADDR_OUT_W-1:0] : '0;
        rsp.success       = ok_reg;
        rsp.page_was_free = was_free_reg;
        rsp.free_pages    = fc_u[pba_pkg::CNT_W-1:0];
        rsp.used_pages    = used_u[pba_pkg::CNT_W-1:0];
        rsp.total_pages   = total_u[pba_pkg::CNT_W-1:0];
    end

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_we, cmd.take_tgt, cmd.free_tgt, cmd.take_hit}))
        else $error("conflicting bitmap writes");

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= NO_PAGE)
        else $error("free count above page total");

    a_lf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lf_reg <= NO_PAGE)
        else $error("lowest free pointer out of range");

endmodule
`default_nettype wire

// ===== src/page_bitmap_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// Page bitmap allocator: allocate lowest / allocate at / free / query.
// ----------------------------------------------------------------------------
// Allocate-at, free and query read the target word, decide and return done;
//   allocate-at of the lowest free page then rescans the words for the pointer.
// Allocate-lowest scans from the pointer, takes the first free page and rescans.
// One transaction at a time; a new one is taken the cycle after done.
// Scan speed is one 64-bit bitmap word per cycle on the single memory read port.
// Reset: every page reserved; a clearing pass over every bitmap word holds busy high.
module page_bitmap_allocator_core #(
    parameter int MAP_WORDS  = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire pba_pkg::req_t             req,
    output logic                           done,
    output pba_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [pba_pkg::CFG_W-1:0] cfg_data
);

    pba_pkg::cmd_t    cmd;
    pba_pkg::status_t status;

    assign cfg_ready = 1'b1;

    pba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req_op (req.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    pba_datapath #(
        .MAP_WORDS  (MAP_WORDS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

// ===== tb/page_bitmap_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core_tb
// Self-checking bench for the page bitmap allocator. A directed table covers
// reset state, address extremes, out-of-range pages, double frees and an
// exhausted map. It is followed by random allocate/free/query traffic over
// several words_in_use settings. Every response is checked against a table value
// or an in-bench bitmap allocator.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core_tb;

    localparam int unsigned MAP_WORDS  = 256;
    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned NO_PAGE    = MAP_WORDS * 64;
    localparam int unsigned FULL_PAGES = MAP_WORDS * 64;
    localparam int unsigned TAIL_WAIT  = 2 * MAP_WORDS + 8;
    localparam int unsigned WATCHDOG   = 5000;
    localparam int unsigned PHASES     = 9;
    localparam int unsigned PHASE_OPS  = 128;

    typedef struct {
        pba_pkg::op_t  op;
        logic [31:0]   addr;
        bit            typed;
        pba_pkg::rsp_t exp;
    } row_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        start     = 1'b0;
    logic                        busy;
    pba_pkg::req_t               req       = '0;
    logic                        done;
    pba_pkg::rsp_t               rsp;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [pba_pkg::CFG_W-1:0]   cfg_data  = '0;

    // allocator mirror
    logic [63:0]        page_bits [MAP_WORDS];
    int unsigned        free_total;
    int unsigned        lowest_page;
    int unsigned        words_set;

    pba_pkg::rsp_t      rsp_due [$];
    pba_pkg::rsp_t      want;
    row_t               plan [$];
    int unsigned        mismatches   = 0;
    int unsigned        stall_cycles = 0;

    int unsigned word_plan [PHASES] = '{256, 0, 1, 4, 511, 2, 300, 64, 256};

    page_bitmap_allocator_core #(
        .MAP_WORDS  (MAP_WORDS),
        .PAGE_BYTES (PAGE_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned eff_words();
        return (words_set > MAP_WORDS) ? MAP_WORDS : words_set;
    endfunction

    function automatic bit page_open(int unsigned pg);
        if (pg / 64 >= eff_words())
        begin
            return 1'b0;
        end
        return !page_bits[pg / 64][pg % 64];
    endfunction

    function automatic int unsigned next_free(int unsigned from);
        int unsigned lim;
        int unsigned p;
        lim = eff_words() * 64;
        p = from;
        while (p < lim)
        begin
            if (p % 64 == 0 && (&page_bits[p / 64]))
            begin
                p += 64;
            end
            else if (!page_bits[p / 64][p % 64])
            begin
                return p;
            end
            else
            begin
                p++;
            end
        end
        return NO_PAGE;
    endfunction

    function automatic void take_page(int unsigned pg);
        page_bits[pg / 64][pg % 64] = 1'b1;
        if (free_total > 0)
        begin
            free_total--;
        end
        if (pg == lowest_page)
        begin
            lowest_page = next_free(pg + 1);
        end
    endfunction

    function automatic pba_pkg::rsp_t apply_page_op(pba_pkg::req_t r);
        pba_pkg::rsp_t o;
        int unsigned   pg;
        int unsigned   p;
        int unsigned   total;
        bit            in_rng;
        o  = '0;
        pg = r.page_address / PAGE_BYTES;
        if (r.op == pba_pkg::OP_ALLOC_ANY)
        begin
            p = next_free(lowest_page);
            if (p == NO_PAGE)
            begin
                lowest_page = NO_PAGE;
            end
            else
            begin
                lowest_page = p;
                take_page(p);
                o.alloc_address = pba_pkg::ADDR_OUT_W'(p * PAGE_BYTES);
                o.success       = 1'b1;
                o.page_was_free = 1'b1;
            end
        end
        else
        begin
            in_rng          = (pg / 64) < eff_words();
            o.page_was_free = page_open(pg);
            if (r.op == pba_pkg::OP_ALLOC_AT && o.page_was_free)
            begin
                take_page(pg);
                o.success = 1'b1;
            end
            else if (r.op == pba_pkg::OP_FREE && in_rng && !o.page_was_free)
            begin
                page_bits[pg / 64][pg % 64] = 1'b0;
                free_total++;
                if (pg < lowest_page)
                begin
                    lowest_page = pg;
                end
                o.success = 1'b1;
            end
        end
        total = eff_words() * 64;
        o.free_pages  = pba_pkg::CNT_W'(free_total);
        o.used_pages  = pba_pkg::CNT_W'((total > free_total) ? total - free_total : 0);
        o.total_pages = pba_pkg::CNT_W'(total);
        return o;
    endfunction

    function automatic pba_pkg::rsp_t known(bit ok, bit was, int unsigned fr,
                                            int unsigned used);
        pba_pkg::rsp_t o;
        o               = '0;
        o.success       = ok;
        o.page_was_free = was;
        o.free_pages    = pba_pkg::CNT_W'(fr);
        o.used_pages    = pba_pkg::CNT_W'(used);
        o.total_pages   = pba_pkg::CNT_W'(FULL_PAGES);
        return o;
    endfunction

    function automatic logic [31:0] pick_address();
        int unsigned span;
        int unsigned top;
        int unsigned pg;
        int unsigned k;
        top  = eff_words() * 64;
        span = (top + 64 < 384) ? top + 64 : 384;
        k    = $urandom_range(0, 9);
        if (k == 9)
        begin
            return $urandom();
        end
        if (k < 7)
        begin
            pg = $urandom_range(0, span - 1);
        end
        else
        begin
            pg = ((top >= 64) ? top - 64 : 0) + $urandom_range(0, 127);
        end
        return (pg * PAGE_BYTES) | $urandom_range(0, PAGE_BYTES - 1);
    endfunction

    task automatic add_row(pba_pkg::op_t op, logic [31:0] addr, bit typed,
                           pba_pkg::rsp_t exp);
        row_t r;
        r.op    = op;
        r.addr  = addr;
        r.typed = typed;
        r.exp   = exp;
        plan.push_back(r);
    endtask

    // leaves start high; the next call with a nonzero gap or drain() lowers it
    task automatic issue(pba_pkg::req_t r, int unsigned gap, bit typed,
                         pba_pkg::rsp_t typed_rsp);
        pba_pkg::rsp_t got;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        got = apply_page_op(r);
        rsp_due.push_back(typed ? typed_rsp : got);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (rsp_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_words(int unsigned v);
        cfg_valid <= 1'b1;
        cfg_data  <= pba_pkg::CFG_W'(v);
        do @(posedge clk); while (!cfg_ready);
        words_set = v;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatches++;
            end
            else
            begin
                want = rsp_due.pop_front();
                if (rsp.alloc_address !== want.alloc_address)
                begin
                    $error("alloc_address: expected %0h, got %0h",
                           want.alloc_address, rsp.alloc_address);
                    mismatches++;
                end
                if (rsp.success !== want.success)
                begin
                    $error("success: expected %0b, got %0b", want.success, rsp.success);
                    mismatches++;
                end
                if (rsp.page_was_free !== want.page_was_free)
                begin
                    $error("page_was_free: expected %0b, got %0b",
                           want.page_was_free, rsp.page_was_free);
                    mismatches++;
                end
                if (rsp.free_pages !== want.free_pages)
                begin
                    $error("free_pages: expected %0d, got %0d",
                           want.free_pages, rsp.free_pages);
                    mismatches++;
                end
                if (rsp.used_pages !== want.used_pages)
                begin
                    $error("used_pages: expected %0d, got %0d",
                           want.used_pages, rsp.used_pages);
                    mismatches++;
                end
                if (rsp.total_pages !== want.total_pages)
                begin
                    $error("total_pages: expected %0d, got %0d",
                           want.total_pages, rsp.total_pages);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        pba_pkg::req_t r;
        int unsigned   k;
        int unsigned   gap;
        bit            no_idle;

        for (int i = 0; i < MAP_WORDS; i++)
        begin
            page_bits[i] = '1;
        end
        free_total  = 0;
        lowest_page = NO_PAGE;
        words_set   = pba_pkg::WORDS_IN_USE_RESET;

        add_row(pba_pkg::OP_QUERY,     32'h0000_0000, 1'b1, known(0, 0, 0, 16384));
        add_row(pba_pkg::OP_ALLOC_ANY, 32'h0000_0000, 1'b1, known(0, 0, 0, 16384));
        add_row(pba_pkg::OP_ALLOC_AT,  32'h0000_0000, 1'b1, known(0, 0, 0, 16384));
        add_row(pba_pkg::OP_FREE,      32'hFFFF_FFFF, 1'b1, known(0, 0, 0, 16384));
        add_row(pba_pkg::OP_FREE,      32'h0000_0000, 1'b1, known(1, 0, 1, 16383));
        add_row(pba_pkg::OP_FREE,      32'h0000_0ABC, 1'b1, known(0, 1, 1, 16383));
        add_row(pba_pkg::OP_FREE,      32'h03FF_F000, 1'b0, '0);
        add_row(pba_pkg::OP_FREE,      32'h0400_0000, 1'b1, known(0, 0, 2, 16382));
        add_row(pba_pkg::OP_FREE,      32'h0003_FFFF, 1'b0, '0);
        add_row(pba_pkg::OP_FREE,      32'h0004_0000, 1'b0, '0);
        add_row(pba_pkg::OP_QUERY,     32'h0003_F000, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_ANY, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_AT,  32'h0003_F123, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_AT,  32'h0003_F000, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_ANY, 32'h0000_0000, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_ANY, 32'h0000_0000, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_ANY, 32'h0000_0000, 1'b1, known(0, 0, 0, 16384));
        add_row(pba_pkg::OP_QUERY,     32'hFFFF_FFFF, 1'b0, '0);
        add_row(pba_pkg::OP_FREE,      32'h0006_4000, 1'b0, '0);
        add_row(pba_pkg::OP_FREE,      32'h0000_5555, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_AT,  32'h0006_4FFF, 1'b0, '0);
        add_row(pba_pkg::OP_ALLOC_ANY, 32'h0000_0000, 1'b0, '0);
        add_row(pba_pkg::OP_QUERY,     32'h0000_5000, 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_words(pba_pkg::WORDS_IN_USE_RESET);

        foreach (plan[i])
        begin
            r.op           = plan[i].op;
            r.page_address = plan[i].addr;
            issue(r, $urandom_range(0, 19), plan[i].typed, plan[i].exp);
        end

        no_idle = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_words(word_plan[ph]);
            for (int i = 0; i < PHASE_OPS; i++)
            begin
                if (i % 32 == 0)
                begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                k = $urandom_range(0, 19);
                if (k < 7)
                begin
                    r.op = pba_pkg::OP_FREE;
                end
                else if (k < 12)
                begin
                    r.op = pba_pkg::OP_ALLOC_ANY;
                end
                else if (k < 16)
                begin
                    r.op = pba_pkg::OP_ALLOC_AT;
                end
                else
                begin
                    r.op = pba_pkg::OP_QUERY;
                end
                r.page_address = pick_address();
                gap = no_idle ? 0 : $urandom_range(0, 19);
                issue(r, gap, 1'b0, '0);
                if ($urandom_range(0, 63) == 0)
                begin
                    drain();
                end
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pba_pkg.sv
src/pba_ctrl.sv
src/pba_datapath.sv
src/page_bitmap_allocator_core.sv
tb/page_bitmap_allocator_core_tb.sv
